// ===== rtl/lr_shift_reduce_parse_engine_unit_assert.svh =====
// assertion macros shared by the parse engine modules
// every macro samples on i_clk and is disabled while i_rst_n is low
`ifndef LR_SHIFT_REDUCE_PARSE_ENGINE_UNIT_ASSERT_SVH
`define LR_SHIFT_REDUCE_PARSE_ENGINE_UNIT_ASSERT_SVH

// condition holds at every edge
`define LRP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define LRP_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define LRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lrp_pkg.sv =====
package lrp_pkg;

    // input command codes
    localparam logic [2:0] CMD_TOKEN     = 3'd0;
    localparam logic [2:0] CMD_WR_ACTION = 3'd1;
    localparam logic [2:0] CMD_WR_GOTO   = 3'd2;
    localparam logic [2:0] CMD_WR_RULE   = 3'd3;
    localparam logic [2:0] CMD_RESTART   = 3'd4;

    // classified operations carried through the queue
    localparam logic [2:0] OP_TOKEN   = 3'd0;
    localparam logic [2:0] OP_WR_ACT  = 3'd1;
    localparam logic [2:0] OP_WR_GOTO = 3'd2;
    localparam logic [2:0] OP_WR_RULE = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;
    localparam logic [2:0] OP_IGNORE  = 3'd5;

    // action kinds
    localparam logic [1:0] AK_UNDEF  = 2'd0;
    localparam logic [1:0] AK_SHIFT  = 2'd1;
    localparam logic [1:0] AK_REDUCE = 2'd2;
    localparam logic [1:0] AK_ACCEPT = 2'd3;

    // result event codes
    localparam logic [2:0] EV_REDUCE  = 3'd0;
    localparam logic [2:0] EV_SHIFT   = 3'd1;
    localparam logic [2:0] EV_ACCEPT  = 3'd2;
    localparam logic [2:0] EV_REJECT  = 3'd3;
    localparam logic [2:0] EV_WRITE   = 3'd4;
    localparam logic [2:0] EV_IGNORED = 3'd5;

    // reject reasons
    localparam logic [2:0] RR_NONE      = 3'd0;
    localparam logic [2:0] RR_NO_ACTION = 3'd1;
    localparam logic [2:0] RR_NO_GOTO   = 3'd2;
    localparam logic [2:0] RR_UNDERFLOW = 3'd3;
    localparam logic [2:0] RR_OVERFLOW  = 3'd4;
    localparam logic [2:0] RR_LIMIT     = 3'd5;

    // reduces allowed for one token
    localparam logic [5:0] REDUCE_LIMIT = 6'd63;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QW      = $clog2(Q_DEPTH);

    // one classified transaction
    typedef struct packed {
        logic [2:0] op;
        logic       col_ok;
        logic [5:0] row;
        logic [7:0] col;
        logic [7:0] data;
        logic [5:0] rule;
    } t_item;

endpackage

// ===== rtl/lr_shift_reduce_parse_engine_unit.sv =====
// channel | direction | handshake         | payload
// input   | in        | i_valid / o_ready | i_command, i_token, table, goto and rule fields
// result  | out       | o_valid / i_ready | o_event_res, o_reduced_rule, o_new_top_state,
//         |           |                   | o_reject_reason, o_last
//
// after reset a clearing pass over max(MAX_STATES*SYMBOL_COUNT, MAX_RULES) addresses
// (2048 at the defaults) zeroes the action, goto and rule memories; o_ready stays low
// a write, restart or ignored transaction is handled in S_IDLE alone
// a token reads its action in S_IDLE and acts on it in S_ACT; each reduce passes through
// S_RULE, S_POP and S_GOTO back to S_ACT, following the chain of registered reads: action, rule, stack, goto
// a two-entry queue keeps the input open while the output register waits on i_ready
module lr_shift_reduce_parse_engine_unit #(
    parameter int MAX_STATES        = 64,
    parameter int SYMBOL_COUNT      = 32,
    parameter int NONTERMINAL_COUNT = 16,
    parameter int MAX_RULES         = 64,
    parameter int STACK_DEPTH       = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_command,
    input  logic [3:0] i_token,
    input  logic [5:0] i_table_state,
    input  logic [4:0] i_table_symbol,
    input  logic [1:0] i_action_kind,
    input  logic [5:0] i_action_operand,
    input  logic       i_goto_valid,
    input  logic [5:0] i_goto_target,
    input  logic [5:0] i_rule_number,
    input  logic [3:0] i_rule_length,
    input  logic [3:0] i_rule_left_side,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_event_res,
    output logic [5:0] o_reduced_rule,
    output logic [5:0] o_new_top_state,
    output logic [2:0] o_reject_reason,
    output logic       o_last
);
    import lrp_pkg::*;

    logic  busy;
    logic  q_ready;
    logic  push;
    t_item in_item;
    logic  q_valid;
    logic  pop;
    t_item q_item;

    // classify incoming transactions
    lrp_front #(
        .MAX_STATES        (MAX_STATES),
        .SYMBOL_COUNT      (SYMBOL_COUNT),
        .NONTERMINAL_COUNT (NONTERMINAL_COUNT),
        .MAX_RULES         (MAX_RULES)
    ) u_front (
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_token          (i_token),
        .i_table_state    (i_table_state),
        .i_table_symbol   (i_table_symbol),
        .i_action_kind    (i_action_kind),
        .i_action_operand (i_action_operand),
        .i_goto_valid     (i_goto_valid),
        .i_goto_target    (i_goto_target),
        .i_rule_number    (i_rule_number),
        .i_rule_length    (i_rule_length),
        .i_rule_left_side (i_rule_left_side),
        .i_busy           (busy),
        .i_q_ready        (q_ready),
        .o_push           (push),
        .o_item           (in_item)
    );

    // decoupling queue
    lrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_item  (q_item)
    );

    // parse engine
    lrp_back #(
        .MAX_STATES        (MAX_STATES),
        .SYMBOL_COUNT      (SYMBOL_COUNT),
        .NONTERMINAL_COUNT (NONTERMINAL_COUNT),
        .MAX_RULES         (MAX_RULES),
        .STACK_DEPTH       (STACK_DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (q_valid),
        .i_item          (q_item),
        .o_pop           (pop),
        .o_busy          (busy),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_event_res     (o_event_res),
        .o_reduced_rule  (o_reduced_rule),
        .o_new_top_state (o_new_top_state),
        .o_reject_reason (o_reject_reason),
        .o_last          (o_last)
    );

endmodule

// ===== rtl/lrp_front.sv =====
module lrp_front #(
    parameter int MAX_STATES        = 64,
    parameter int SYMBOL_COUNT      = 32,
    parameter int NONTERMINAL_COUNT = 16,
    parameter int MAX_RULES         = 64
) (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [2:0]    i_command,
    input  logic [3:0]    i_token,
    input  logic [5:0]    i_table_state,
    input  logic [4:0]    i_table_symbol,
    input  logic [1:0]    i_action_kind,
    input  logic [5:0]    i_action_operand,
    input  logic          i_goto_valid,
    input  logic [5:0]    i_goto_target,
    input  logic [5:0]    i_rule_number,
    input  logic [3:0]    i_rule_length,
    input  logic [3:0]    i_rule_left_side,
    input  logic          i_busy,
    input  logic          i_q_ready,
    output logic          o_push,
    output lrp_pkg::t_item o_item
);
    import lrp_pkg::*;

    logic cell_ok;
    logic rule_ok;
    logic tok_col_ok;
    int   tok_col;

    // accept only when the queue has room and the stores are not being cleared
    assign o_ready = i_q_ready && !i_busy;
    assign o_push  = i_valid && o_ready;

    // range checks
    assign cell_ok    = (32'(i_table_state) < MAX_STATES) && (32'(i_table_symbol) < SYMBOL_COUNT);
    assign rule_ok    = 32'(i_rule_number) < MAX_RULES;
    assign tok_col    = NONTERMINAL_COUNT + 32'(i_token);
    assign tok_col_ok = tok_col < SYMBOL_COUNT;

    // classify the command and pack the fields it needs
    always_comb begin
        o_item        = '0;
        o_item.row    = i_table_state;
        o_item.col    = 8'(i_table_symbol);
        o_item.rule   = i_rule_number;
        o_item.col_ok = 1'b0;
        unique case (i_command)
            CMD_TOKEN: begin
                o_item.op     = OP_TOKEN;
                o_item.col    = 8'(tok_col);
                o_item.col_ok = tok_col_ok;
            end
            CMD_WR_ACTION: begin
                o_item.op   = cell_ok ? OP_WR_ACT : OP_IGNORE;
                o_item.data = {i_action_kind, i_action_operand};
            end
            CMD_WR_GOTO: begin
                o_item.op   = cell_ok ? OP_WR_GOTO : OP_IGNORE;
                o_item.data = {1'b0, i_goto_valid, i_goto_target};
            end
            CMD_WR_RULE: begin
                o_item.op   = rule_ok ? OP_WR_RULE : OP_IGNORE;
                o_item.data = {i_rule_length, i_rule_left_side};
            end
            CMD_RESTART: begin
                o_item.op = OP_RESTART;
            end
            default: begin
                o_item.op = OP_IGNORE;
            end
        endcase
    end

endmodule

// ===== rtl/lrp_queue.sv =====
module lrp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  lrp_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_pop,
    output lrp_pkg::t_item o_item
);
    import lrp_pkg::*;

    t_item          r_slot [Q_DEPTH];
    logic [QW-1:0]  r_wptr;
    logic [QW-1:0]  r_rptr;
    logic [QW:0]    r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_ready = 32'(r_cnt) < Q_DEPTH;
    assign o_valid = r_cnt != '0;
    assign o_item  = r_slot[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (32'(r_wptr) == Q_DEPTH - 1) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (32'(r_rptr) == Q_DEPTH - 1) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

endmodule

// ===== rtl/lrp_back.sv =====
`include "lr_shift_reduce_parse_engine_unit_assert.svh"

module lrp_back #(
    parameter int MAX_STATES        = 64,
    parameter int SYMBOL_COUNT      = 32,
    parameter int NONTERMINAL_COUNT = 16,
    parameter int MAX_RULES         = 64,
    parameter int STACK_DEPTH       = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  lrp_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_busy,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [2:0]     o_event_res,
    output logic [5:0]     o_reduced_rule,
    output logic [5:0]     o_new_top_state,
    output logic [2:0]     o_reject_reason,
    output logic           o_last
);
    import lrp_pkg::*;

    localparam int ENTRIES = MAX_STATES * SYMBOL_COUNT;
    localparam int AW      = $clog2(ENTRIES);
    localparam int RW      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int SW      = $clog2(STACK_DEPTH);
    localparam int CW      = $clog2(STACK_DEPTH + 1);
    localparam int CLR_LEN = (ENTRIES > MAX_RULES) ? ENTRIES : MAX_RULES;
    localparam int CLW     = $clog2(CLR_LEN);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_ACT    = 3'd2;
    localparam logic [2:0] S_RULE   = 3'd3;
    localparam logic [2:0] S_POP    = 3'd4;
    localparam logic [2:0] S_GOTO   = 3'd5;
    localparam logic [2:0] S_NOGOTO = 3'd6;

    // table and stack memories
    logic [7:0] r_act_mem  [ENTRIES];
    logic [6:0] r_goto_mem [ENTRIES];
    logic [7:0] r_rule_mem [MAX_RULES];
    logic [5:0] r_stk_mem  [STACK_DEPTH];

    logic [7:0] r_act_rd;
    logic [6:0] r_goto_rd;
    logic [7:0] r_rule_rd;
    logic [5:0] r_stk_rd;

    // control state
    logic [2:0]     r_state,   n_state;
    logic [CLW-1:0] r_clr,     n_clr;
    logic [5:0]     r_top,     n_top;
    logic [CW-1:0]  r_count,   n_count;
    logic           r_done,    n_done;
    logic [5:0]     r_reduces, n_reduces;
    logic [7:0]     r_col,     n_col;
    logic           r_col_ok,  n_col_ok;
    logic           r_act_ok,  n_act_ok;
    logic           r_rule_ok, n_rule_ok;
    logic           r_goto_ok, n_goto_ok;
    logic [5:0]     r_opnd,    n_opnd;
    logic [3:0]     r_left,    n_left;

    // output register
    logic       r_o_valid;
    logic [2:0] r_o_event;
    logic [5:0] r_o_rule;
    logic [5:0] r_o_top;
    logic [2:0] r_o_reason;
    logic       r_o_last;

    // memory ports
    logic          act_we,  goto_we,  rule_we,  stk_we;
    logic [AW-1:0] act_wa,  goto_wa;
    logic [RW-1:0] rule_wa;
    logic [SW-1:0] stk_wa;
    logic [7:0]    act_wd,  rule_wd;
    logic [6:0]    goto_wd;
    logic [5:0]    stk_wd;
    logic          act_re,  goto_re,  rule_re,  stk_re;
    logic [AW-1:0] act_ra,  goto_ra;
    logic [RW-1:0] rule_ra;
    logic [SW-1:0] stk_ra;

    // result being issued this cycle
    logic       em_valid;
    logic [2:0] em_event;
    logic [5:0] em_rule;
    logic [5:0] em_top;
    logic [2:0] em_reason;
    logic       em_last;

    logic       out_free;
    logic [7:0] act_word;
    logic [7:0] rule_word;
    logic [6:0] goto_word;
    logic [1:0] act_kind;
    logic [5:0] act_opnd;
    logic [3:0] rule_len;
    logic [3:0] rule_left;
    logic       stack_full;

    function automatic logic [AW-1:0] tbl_addr(input logic [5:0] row, input logic [7:0] col);
        return AW'(32'(row) * SYMBOL_COUNT + 32'(col));
    endfunction

    function automatic logic st_ok(input logic [5:0] st);
        return 32'(st) < MAX_STATES;
    endfunction

    assign out_free   = !r_o_valid || i_ready;
    assign act_word   = r_act_ok ? r_act_rd : 8'd0;
    assign rule_word  = r_rule_ok ? r_rule_rd : 8'd0;
    assign goto_word  = r_goto_ok ? r_goto_rd : 7'd0;
    assign act_kind   = act_word[7:6];
    assign act_opnd   = act_word[5:0];
    assign rule_len   = rule_word[7:4];
    assign rule_left  = rule_word[3:0];
    assign stack_full = 32'(r_count) >= STACK_DEPTH;
    assign o_busy     = r_state == S_CLEAR;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_top     = r_top;
        n_count   = r_count;
        n_done    = r_done;
        n_reduces = r_reduces;
        n_col     = r_col;
        n_col_ok  = r_col_ok;
        n_act_ok  = r_act_ok;
        n_rule_ok = r_rule_ok;
        n_goto_ok = r_goto_ok;
        n_opnd    = r_opnd;
        n_left    = r_left;

        o_pop   = 1'b0;
        act_we  = 1'b0;  act_wa  = '0;  act_wd  = '0;
        goto_we = 1'b0;  goto_wa = '0;  goto_wd = '0;
        rule_we = 1'b0;  rule_wa = '0;  rule_wd = '0;
        stk_we  = 1'b0;  stk_wa  = '0;  stk_wd  = '0;
        act_re  = 1'b0;  act_ra  = '0;
        goto_re = 1'b0;  goto_ra = '0;
        rule_re = 1'b0;  rule_ra = '0;
        stk_re  = 1'b0;  stk_ra  = '0;

        em_valid  = 1'b0;
        em_event  = EV_IGNORED;
        em_rule   = 6'd0;
        em_top    = r_top;
        em_reason = RR_NONE;
        em_last   = 1'b1;

        unique case (r_state)
            // zero the action, goto and rule stores and write state 0 into stack entry 0
            S_CLEAR: begin
                act_we  = 32'(r_clr) < ENTRIES;
                act_wa  = AW'(r_clr);
                goto_we = 32'(r_clr) < ENTRIES;
                goto_wa = AW'(r_clr);
                rule_we = 32'(r_clr) < MAX_RULES;
                rule_wa = RW'(r_clr);
                stk_we  = 1'b1;
                if (32'(r_clr) == CLR_LEN - 1) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            // take the next transaction from the queue
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    o_pop    = 1'b1;
                    em_valid = 1'b1;
                    em_event = EV_WRITE;
                    unique case (i_item.op)
                        OP_WR_ACT: begin
                            act_we = 1'b1;
                            act_wa = tbl_addr(i_item.row, i_item.col);
                            act_wd = i_item.data;
                        end
                        OP_WR_GOTO: begin
                            goto_we = 1'b1;
                            goto_wa = tbl_addr(i_item.row, i_item.col);
                            goto_wd = i_item.data[6:0];
                        end
                        OP_WR_RULE: begin
                            rule_we = 1'b1;
                            rule_wa = RW'(i_item.rule);
                            rule_wd = i_item.data;
                        end
                        OP_RESTART: begin
                            stk_we  = 1'b1;
                            n_top   = 6'd0;
                            n_count = CW'(1);
                            n_done  = 1'b0;
                            em_top  = 6'd0;
                        end
                        OP_TOKEN: begin
                            if (r_done) begin
                                em_event = EV_IGNORED;
                            end else begin
                                em_valid  = 1'b0;
                                act_re    = 1'b1;
                                act_ra    = tbl_addr(r_top, i_item.col);
                                n_act_ok  = i_item.col_ok && st_ok(r_top);
                                n_col     = i_item.col;
                                n_col_ok  = i_item.col_ok;
                                n_reduces = 6'd0;
                                n_state   = S_ACT;
                            end
                        end
                        default: begin
                            em_event = EV_IGNORED;
                        end
                    endcase
                end
            end

            // act on the looked-up action
            S_ACT: begin
                unique case (act_kind)
                    AK_UNDEF: begin
                        if (out_free) begin
                            em_valid  = 1'b1;
                            em_event  = EV_REJECT;
                            em_reason = RR_NO_ACTION;
                            n_done    = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    AK_ACCEPT: begin
                        if (out_free) begin
                            em_valid = 1'b1;
                            em_event = EV_ACCEPT;
                            n_done   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    AK_SHIFT: begin
                        if (out_free) begin
                            em_valid = 1'b1;
                            n_state  = S_IDLE;
                            if (stack_full) begin
                                em_event  = EV_REJECT;
                                em_reason = RR_OVERFLOW;
                                n_done    = 1'b1;
                            end else begin
                                stk_we   = 1'b1;
                                stk_wa   = SW'(r_count);
                                stk_wd   = act_opnd;
                                n_top    = act_opnd;
                                n_count  = r_count + 1'b1;
                                em_event = EV_SHIFT;
                                em_top   = act_opnd;
                            end
                        end
                    end
                    AK_REDUCE: begin
                        if (r_reduces >= REDUCE_LIMIT) begin
                            if (out_free) begin
                                em_valid  = 1'b1;
                                em_event  = EV_REJECT;
                                em_reason = RR_LIMIT;
                                n_done    = 1'b1;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            rule_re   = 1'b1;
                            rule_ra   = RW'(act_opnd);
                            n_rule_ok = 32'(act_opnd) < MAX_RULES;
                            n_opnd    = act_opnd;
                            n_state   = S_RULE;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // pop the right-hand side and fetch the exposed state
            S_RULE: begin
                if (32'(rule_len) >= 32'(r_count)) begin
                    if (out_free) begin
                        em_valid  = 1'b1;
                        em_event  = EV_REJECT;
                        em_reason = RR_UNDERFLOW;
                        n_done    = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_count   = r_count - CW'(rule_len);
                    stk_re    = 1'b1;
                    stk_ra    = SW'(r_count - CW'(rule_len) - CW'(1));
                    n_left    = rule_left;
                    n_reduces = r_reduces + 1'b1;
                    n_state   = S_POP;
                end
            end

            // new top known, look up its goto entry
            S_POP: begin
                n_top     = r_stk_rd;
                goto_re   = 1'b1;
                goto_ra   = tbl_addr(r_stk_rd, 8'(r_left));
                n_goto_ok = st_ok(r_stk_rd) && (32'(r_left) < NONTERMINAL_COUNT)
                            && (32'(r_left) < SYMBOL_COUNT);
                n_state   = S_GOTO;
            end

            // report the reduce and, when the goto entry is valid, push its target if the stack has room
            S_GOTO: begin
                if (out_free) begin
                    em_valid = 1'b1;
                    em_event = EV_REDUCE;
                    em_rule  = r_opnd;
                    em_last  = 1'b0;
                    if (!goto_word[6]) begin
                        n_done  = 1'b1;
                        n_state = S_NOGOTO;
                    end else begin
                        stk_we   = !stack_full;
                        stk_wa   = SW'(r_count);
                        stk_wd   = goto_word[5:0];
                        n_count  = stack_full ? r_count : r_count + 1'b1;
                        n_top    = goto_word[5:0];
                        em_top   = goto_word[5:0];
                        act_re   = 1'b1;
                        act_ra   = tbl_addr(goto_word[5:0], r_col);
                        n_act_ok = r_col_ok && st_ok(goto_word[5:0]);
                        n_state  = S_ACT;
                    end
                end
            end

            // reject after a reduce that found no goto
            S_NOGOTO: begin
                if (out_free) begin
                    em_valid  = 1'b1;
                    em_event  = EV_REJECT;
                    em_reason = RR_NO_GOTO;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_top     <= 6'd0;
            r_count   <= CW'(1);
            r_done    <= 1'b0;
            r_reduces <= 6'd0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_top     <= n_top;
            r_count   <= n_count;
            r_done    <= n_done;
            r_reduces <= n_reduces;
        end
    end

    // lookup context
    always_ff @(posedge i_clk) begin
        r_col     <= n_col;
        r_col_ok  <= n_col_ok;
        r_act_ok  <= n_act_ok;
        r_rule_ok <= n_rule_ok;
        r_goto_ok <= n_goto_ok;
        r_opnd    <= n_opnd;
        r_left    <= n_left;
    end

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (act_we) begin
            r_act_mem[act_wa] <= act_wd;
        end
        if (act_re) begin
            r_act_rd <= r_act_mem[act_ra];
        end
        if (goto_we) begin
            r_goto_mem[goto_wa] <= goto_wd;
        end
        if (goto_re) begin
            r_goto_rd <= r_goto_mem[goto_ra];
        end
        if (rule_we) begin
            r_rule_mem[rule_wa] <= rule_wd;
        end
        if (rule_re) begin
            r_rule_rd <= r_rule_mem[rule_ra];
        end
        if (stk_we) begin
            r_stk_mem[stk_wa] <= stk_wd;
        end
        if (stk_re) begin
            r_stk_rd <= r_stk_mem[stk_ra];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (em_valid) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (em_valid) begin
            r_o_event  <= em_event;
            r_o_rule   <= em_rule;
            r_o_top    <= em_top;
            r_o_reason <= em_reason;
            r_o_last   <= em_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_event_res     = r_o_event;
    assign o_reduced_rule  = r_o_rule;
    assign o_new_top_state = r_o_top;
    assign o_reject_reason = r_o_reason;
    assign o_last          = r_o_last;

    // checks
    `LRP_ASSERT_ALWAYS(a_count_range, (r_count != '0) && (32'(r_count) <= STACK_DEPTH), "stack count out of range")
    `LRP_ASSERT_IMPLY(a_clear_quiet, r_state == S_CLEAR, !o_pop && !em_valid, "activity during clear")
    `LRP_ASSERT_NEXT(a_last_idle, em_valid && em_last, r_state == S_IDLE, "final result not followed by idle")
    `LRP_ASSERT_IMPLY(a_live_parse, (r_state == S_ACT) || (r_state == S_RULE) || (r_state == S_POP) || (r_state == S_GOTO), !r_done, "token worked after finish")

endmodule
